// ===== rtl/core/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

    localparam int MAP_FRAMES  = 4096;
    localparam int FRAME_SHIFT = 12;
    localparam int ADDR_W      = 32;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int ROWS        = MAP_FRAMES / WORD_W;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int IDX_W       = $clog2(MAP_FRAMES) + 1;
    localparam int FN_W        = ADDR_W - FRAME_SHIFT + 1;

    localparam logic [2:0] M_ALLOC_ONE = 3'd0;
    localparam logic [2:0] M_FREE_ONE  = 3'd1;
    localparam logic [2:0] M_RESERVE   = 3'd2;
    localparam logic [2:0] M_ALLOC_RUN = 3'd3;
    localparam logic [2:0] M_FREE_RUN  = 3'd4;

    localparam logic CFG_POOL_BASE = 1'b0;
    localparam logic CFG_RAM_TOP   = 1'b1;

    typedef struct packed {
        logic [2:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [ADDR_W-1:0] end_address;
        logic [ADDR_W-1:0] byte_count;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] frame_address;
        logic              granted;
        logic [IDX_W-1:0]  free_count;
    } out_item_t;

    typedef struct packed {
        logic             clear;
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
    } ram_ctl_t;

    // Frames covering a byte count, rounded up without wrap
    function automatic logic [FN_W-1:0] frames_for(input logic [ADDR_W-1:0] b);
        logic rem;
        rem = |b[FRAME_SHIFT-1:0];
        return FN_W'(b >> FRAME_SHIFT) + FN_W'(rem);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bfa_map_ram.sv =====
`default_nettype none

module bfa_map_ram (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire bfa_pkg::ram_ctl_t       ctl,
    input  wire  [bfa_pkg::WORD_W-1:0]   wr_data,
    output logic [bfa_pkg::WORD_W-1:0]   rd_data
);
    import bfa_pkg::*;

    logic [WORD_W-1:0] mem [ROWS];
    logic [ROWS-1:0]   valid_reg;
    logic [WORD_W-1:0] data_reg;
    logic              hit_reg;

    // Row valid bits: a row never written reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.rd_en)
                hit_reg <= valid_reg[ctl.rd_row];
            if (ctl.clear)
                valid_reg <= '0;
            else if (ctl.wr_en)
                valid_reg[ctl.wr_row] <= 1'b1;
        end
    end

    // Word storage
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
            mem[ctl.wr_row] <= wr_data;
        if (ctl.rd_en)
            data_reg <= mem[ctl.rd_row];
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_frame_allocator.sv =====
`default_nettype none

// Bitmap frame allocator: one used bit per frame over the pool between
// the pool base address and ram_top, kept in a 128 x 32 word RAM.
// Configuration: cfg_we/cfg_index/cfg_data write the pool base (0) or ram_top
// (1) while the block is idle; each write empties the pool.
// Input channel in_valid/in_ready/in_item carries one request; the block
// takes one request at a time and drops in_ready until its result is loaded
// into the output register. Output channel out_valid/out_ready/out_item
// holds the result until taken; a stalled receiver only delays the next
// acceptance by holding the result register.
// A single sequencer walks the map one frame per cycle within a word, and
// reads, loads and writes back each 32-frame word it touches. Free-one
// touches one frame; alloc-one walks from the hint to the first free frame;
// reserve and run free walk the range; run alloc scans up to the whole pool
// for a free run, then walks back over the run to mark it.
// Reset empties the map at once through per-row valid bits, clears the
// count, the hint and both registers.

module bitmap_frame_allocator (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_we,
    input  wire                          cfg_index,
    input  wire  [bfa_pkg::ADDR_W-1:0]   cfg_data,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire bfa_pkg::in_item_t       in_item,
    output logic                         out_valid,
    input  wire                          out_ready,
    output bfa_pkg::out_item_t           out_item
);
    import bfa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_RD    = 7'b0000100,
        S_LD    = 7'b0001000,
        S_BIT   = 7'b0010000,
        S_WB    = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    in_item_t          req_reg;
    logic [ADDR_W-1:0] base_reg, top_reg;
    logic [IDX_W-1:0]  pf_reg, pf_next;
    logic [IDX_W-1:0]  used_reg, used_next;
    logic [IDX_W-1:0]  hint_reg, hint_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  need_reg, need_next;
    logic [IDX_W-1:0]  rstart_reg, rstart_next;
    logic [IDX_W-1:0]  rlen_reg, rlen_next;
    logic              mark_reg, mark_next;
    logic              done_reg, done_next;
    logic              ok_reg, ok_next;
    logic [ADDR_W-1:0] res_reg, res_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              out_valid_reg;
    out_item_t         out_reg;
    ram_ctl_t          ram_ctl;
    logic [WORD_W-1:0] ram_q;

    // Setup terms
    logic [ADDR_W-1:0] diff, off, a2, end_off;
    logic              ge_base;
    logic [FN_W-1:0]   fi, first2, last2, need_b;
    logic [FN_W:0]     sum4;
    logic [FN_W:0]     pf_w;
    logic              go;
    logic [IDX_W-1:0]  lo_s, hi_s;
    logic              cur_bit, last_step;
    logic [IDX_W-1:0]  inc_idx;

    // Pool size follows the registers
    always_comb
    begin
        diff = top_reg - base_reg;
        if (top_reg <= base_reg)
            pf_next = '0;
        else if ((diff >> FRAME_SHIFT) > ADDR_W'(MAP_FRAMES))
            pf_next = IDX_W'(MAP_FRAMES);
        else
            pf_next = IDX_W'(diff >> FRAME_SHIFT);
    end

    // Work out the frame range of the request
    always_comb
    begin
        pf_w    = (FN_W+1)'(pf_reg);
        ge_base = req_reg.address >= base_reg;
        off     = req_reg.address - base_reg;
        fi      = FN_W'(off >> FRAME_SHIFT);
        a2      = (req_reg.address < base_reg) ? base_reg : req_reg.address;
        first2  = FN_W'((a2 - base_reg) >> FRAME_SHIFT);
        end_off = req_reg.end_address - base_reg;
        last2   = frames_for(end_off);
        need_b  = frames_for(req_reg.byte_count);
        sum4    = (FN_W+1)'(fi) + (FN_W+1)'(need_b);
        go      = 1'b0;
        lo_s    = '0;
        hi_s    = '0;
        case (req_reg.mode)
            M_ALLOC_ONE:
            begin
                go   = used_reg < pf_reg;
                lo_s = hint_reg;
                hi_s = pf_reg;
            end
            M_FREE_ONE:
            begin
                go   = ge_base && ((FN_W+1)'(fi) < pf_w);
                lo_s = IDX_W'(fi);
                hi_s = IDX_W'(fi) + IDX_W'(1);
            end
            M_RESERVE:
            begin
                lo_s = IDX_W'(first2);
                hi_s = ((FN_W+1)'(last2) > pf_w) ? pf_reg : IDX_W'(last2);
                go   = (req_reg.end_address > base_reg)
                    && (req_reg.end_address > req_reg.address)
                    && ((FN_W+1)'(first2) < pf_w)
                    && ((FN_W+1)'(first2) < (FN_W+1)'(last2));
            end
            M_ALLOC_RUN:
            begin
                go   = (req_reg.byte_count != '0) && (pf_reg != '0)
                    && ((FN_W+1)'(need_b) <= pf_w);
                lo_s = '0;
                hi_s = pf_reg;
            end
            M_FREE_RUN:
            begin
                go   = ge_base && (req_reg.byte_count != '0)
                    && ((FN_W+1)'(fi) < pf_w);
                lo_s = IDX_W'(fi);
                hi_s = (sum4 > pf_w) ? pf_reg : IDX_W'(sum4);
            end
            default:
            begin
                go = 1'b0;
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        hint_next   = hint_reg;
        idx_next    = idx_reg;
        hi_next     = hi_reg;
        need_next   = need_reg;
        rstart_next = rstart_reg;
        rlen_next   = rlen_reg;
        mark_next   = mark_reg;
        done_next   = done_reg;
        ok_next     = ok_reg;
        res_next    = res_reg;
        word_next   = word_reg;
        cur_bit     = word_reg[idx_reg[BIT_W-1:0]];
        inc_idx     = idx_reg + IDX_W'(1);
        last_step   = 1'b0;
        ram_ctl        = '0;
        ram_ctl.clear  = cfg_we;
        ram_ctl.rd_row = idx_reg[ROW_W+BIT_W-1:BIT_W];
        ram_ctl.wr_row = idx_reg[ROW_W+BIT_W-1:BIT_W];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                idx_next    = lo_s;
                hi_next     = hi_s;
                need_next   = IDX_W'(need_b);
                rstart_next = '0;
                rlen_next   = '0;
                mark_next   = 1'b0;
                done_next   = 1'b0;
                ok_next     = 1'b0;
                res_next    = '0;
                state_next  = go ? S_RD : S_OUT;
            end
            S_RD:
            begin
                ram_ctl.rd_en = 1'b1;
                state_next    = S_LD;
            end
            S_LD:
            begin
                word_next  = ram_q;
                state_next = S_BIT;
            end
            S_BIT:
            begin
                case (req_reg.mode)
                    M_ALLOC_ONE:
                    begin
                        if (inc_idx >= pf_reg)
                            inc_idx = '0;
                        if (!cur_bit)
                        begin
                            word_next[idx_reg[BIT_W-1:0]] = 1'b1;
                            used_next = used_reg + IDX_W'(1);
                            hint_next = inc_idx;
                            res_next  = base_reg + (ADDR_W'(idx_reg) << FRAME_SHIFT);
                            ok_next   = 1'b1;
                            last_step = 1'b1;
                        end
                    end
                    M_FREE_ONE, M_FREE_RUN:
                    begin
                        if (cur_bit)
                        begin
                            word_next[idx_reg[BIT_W-1:0]] = 1'b0;
                            used_next = used_reg - IDX_W'(1);
                        end
                        last_step = inc_idx == hi_reg;
                    end
                    M_RESERVE:
                    begin
                        if (!cur_bit)
                        begin
                            word_next[idx_reg[BIT_W-1:0]] = 1'b1;
                            used_next = used_reg + IDX_W'(1);
                        end
                        last_step = inc_idx == hi_reg;
                    end
                    M_ALLOC_RUN:
                    begin
                        if (mark_reg)
                        begin
                            word_next[idx_reg[BIT_W-1:0]] = 1'b1;
                            used_next = used_reg + IDX_W'(1);
                            last_step = inc_idx == hi_reg;
                            if (last_step)
                            begin
                                ok_next  = 1'b1;
                                res_next = base_reg + (ADDR_W'(rstart_reg) << FRAME_SHIFT);
                            end
                        end
                        else if (!cur_bit && (rlen_reg + IDX_W'(1) == need_reg))
                        begin
                            // Run found: go back and mark it
                            mark_next = 1'b1;
                            inc_idx   = rstart_reg;
                            hi_next   = rstart_reg + need_reg;
                        end
                        else
                        begin
                            if (!cur_bit)
                                rlen_next = rlen_reg + IDX_W'(1);
                            else
                            begin
                                rstart_next = inc_idx;
                                rlen_next   = '0;
                            end
                            last_step = inc_idx == pf_reg;
                        end
                    end
                    default:
                    begin
                        last_step = 1'b1;
                    end
                endcase
                idx_next = inc_idx;
                if (last_step)
                begin
                    done_next  = 1'b1;
                    idx_next   = idx_reg;
                    state_next = S_WB;
                end
                else if (mark_next != mark_reg
                    || inc_idx[IDX_W-1:BIT_W] != idx_reg[IDX_W-1:BIT_W])
                begin
                    // Write back before the walk leaves this word
                    idx_next   = idx_reg;
                    state_next = S_WB;
                end
                if (state_next == S_WB)
                    rstart_next = (mark_next != mark_reg) ? rstart_reg : rstart_next;
            end
            S_WB:
            begin
                ram_ctl.wr_en = 1'b1;
                if (done_reg)
                    state_next = S_OUT;
                else
                begin
                    state_next = S_RD;
                    // Run just found at its last frame: restart at its first frame
                    if (mark_reg && idx_reg == hi_reg - IDX_W'(1))
                        idx_next = rstart_reg;
                    else
                        idx_next = idx_reg + IDX_W'(1);
                    if (req_reg.mode == M_ALLOC_ONE && idx_next >= pf_reg)
                        idx_next = '0;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    bfa_map_ram u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ram_ctl),
        .wr_data (word_reg),
        .rd_data (ram_q)
    );

    // Control and bookkeeping registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= '0;
            top_reg       <= '0;
            pf_reg        <= '0;
            used_reg      <= '0;
            hint_reg      <= '0;
            mark_reg      <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pf_reg    <= pf_next;
            mark_reg  <= mark_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_POOL_BASE)
                    base_reg <= cfg_data;
                else
                    top_reg <= cfg_data;
                used_reg <= '0;
                hint_reg <= '0;
            end
            else
            begin
                used_reg <= used_next;
                hint_reg <= hint_next;
            end
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_item;
        idx_reg    <= idx_next;
        hi_reg     <= hi_next;
        need_reg   <= need_next;
        rstart_reg <= rstart_next;
        rlen_reg   <= rlen_next;
        ok_reg     <= ok_next;
        res_reg    <= res_next;
        word_reg   <= word_next;
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            out_reg.frame_address <= res_reg;
            out_reg.granted       <= ok_reg;
            out_reg.free_count    <= pf_reg - used_reg;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= pf_reg)
        else $error("used count exceeds pool size");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_BIT |-> idx_reg < pf_reg)
        else $error("walk index outside the pool");
    a_grant_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.granted |-> out_reg.frame_address >= base_reg
            || base_reg + (ADDR_W'(pf_reg) << FRAME_SHIFT) < base_reg)
        else $error("granted address below the pool base");
`endif

endmodule

`default_nettype wire
